// ----- hdl/bfsp_pkg.sv -----
// Shared types, codes and constants of the shortest path core.
// No dependencies; every other file refers to it by scoped names.
package bfsp_pkg;

  localparam int DEFAULT_NUM_VERTICES = 8;
  localparam int VERTEX_W = 3;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic [VERTEX_W-1:0]        from_vertex;
    logic [VERTEX_W-1:0]        to_vertex;
    logic signed [WEIGHT_W-1:0] edge_weight;
  } item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]      vertex;
    logic                     reachable;
    logic signed [DIST_W-1:0] distance;
    logic                     has_parent;
    logic [VERTEX_W-1:0]      parent;
    logic                     converged;
    logic                     last;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_EDGE,
    ST_DRAIN,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic load_en;
    logic start;
    logic init_en;
    logic row_rd;
    logic edge_en;
    logic next_row;
    logic pass_end;
    logic finish;
    logic out_rd;
    logic out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic k_last;
    logic v_last;
    logic u_last;
    logic pass_last;
    logic changed;
    logic out_free;
    logic run_req;
  } ctrl_status_t;

endpackage

// ----- hdl/bfsp_ctrl.sv -----
// Sequencer of the shortest path core: clear, load, init, relax passes, output.
// Depends on bfsp_pkg for the state, command and status types.
module bfsp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  bfsp_pkg::ctrl_status_t status,
  output logic                  item_stall,
  output bfsp_pkg::ctrl_cmd_t    cmd
);

  bfsp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfsp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bfsp_pkg::ST_CLEAR: begin
        if (status.clr_last) state_next = bfsp_pkg::ST_IDLE;
      end
      bfsp_pkg::ST_IDLE: begin
        if (item_valid && status.run_req) state_next = bfsp_pkg::ST_INIT;
      end
      bfsp_pkg::ST_INIT: begin
        if (status.k_last) state_next = bfsp_pkg::ST_ROW;
      end
      bfsp_pkg::ST_ROW: begin
        state_next = bfsp_pkg::ST_EDGE;
      end
      bfsp_pkg::ST_EDGE: begin
        if (status.v_last) state_next = bfsp_pkg::ST_DRAIN;
      end
      bfsp_pkg::ST_DRAIN: begin
        priority if (!status.u_last) begin
          state_next = bfsp_pkg::ST_ROW;
        end else if (!status.changed || status.pass_last) begin
          state_next = bfsp_pkg::ST_OUT_RD;
        end else begin
          state_next = bfsp_pkg::ST_ROW;
        end
      end
      bfsp_pkg::ST_OUT_RD: begin
        if (status.out_free) state_next = bfsp_pkg::ST_OUT_LD;
      end
      bfsp_pkg::ST_OUT_LD: begin
        state_next = status.k_last ? bfsp_pkg::ST_IDLE : bfsp_pkg::ST_OUT_RD;
      end
      default: begin
        state_next = bfsp_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      bfsp_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      bfsp_pkg::ST_IDLE: begin
        item_stall  = 1'b0;
        cmd.load_en = item_valid && !status.run_req;
        cmd.start   = item_valid && status.run_req;
      end
      bfsp_pkg::ST_INIT: begin
        cmd.init_en = 1'b1;
      end
      bfsp_pkg::ST_ROW: begin
        cmd.row_rd = 1'b1;
      end
      bfsp_pkg::ST_EDGE: begin
        cmd.edge_en = 1'b1;
      end
      bfsp_pkg::ST_DRAIN: begin
        cmd.next_row = 1'b1;
        if (status.u_last) begin
          cmd.finish   = !status.changed || status.pass_last;
          cmd.pass_end = status.changed && !status.pass_last;
        end
      end
      bfsp_pkg::ST_OUT_RD: begin
        cmd.out_rd = status.out_free;
      end
      bfsp_pkg::ST_OUT_LD: begin
        cmd.out_ld = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hdl/bfsp_datapath.sv -----
// Weight matrix store, vertex state store, counters and the relaxation unit.
// Depends on bfsp_pkg; driven by the commands of bfsp_ctrl.
module bfsp_datapath #(
  parameter int NUM_VERTICES = bfsp_pkg::DEFAULT_NUM_VERTICES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bfsp_pkg::VERTEX_W-1:0]   cfg_data,
  input  bfsp_pkg::item_t                 item,
  input  logic                            result_stall,
  input  bfsp_pkg::ctrl_cmd_t             cmd,
  output bfsp_pkg::ctrl_status_t          status,
  output logic                            result_valid,
  output bfsp_pkg::result_t               result
);

  localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int NE = NUM_VERTICES * NUM_VERTICES;
  localparam int AW = $clog2(NE);
  localparam int WW = bfsp_pkg::WEIGHT_W;
  localparam int DW = bfsp_pkg::DIST_W;
  localparam logic [VW-1:0] LAST_V = VW'(NUM_VERTICES - 1);
  localparam logic [AW-1:0] LAST_E = AW'(NE - 1);
  localparam logic signed [DW-1:0] DIST_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DIST_MIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [WW-1:0] wmem [NE];
  logic signed [DW-1:0] dist_mem [NUM_VERTICES];
  logic                 reach_mem [NUM_VERTICES];
  logic                 pval_mem [NUM_VERTICES];
  logic [VW-1:0]        par_mem [NUM_VERTICES];

  logic signed [WW-1:0] w_rd;
  logic signed [DW-1:0] dist_rd;
  logic                 reach_rd;
  logic                 pval_rd;
  logic [VW-1:0]        par_rd;

  logic [AW-1:0] clr_cnt;
  logic [VW-1:0] u, v, k, pass_cnt, s1_v;
  logic          s1_valid, du_load, du_reach, changed_reg, converged;
  logic signed [DW-1:0] du;
  logic [bfsp_pkg::VERTEX_W-1:0] src;

  logic                 load_ok, src_ok, init_reach, relax;
  logic                 w_we, s_we;
  logic [AW-1:0]        w_waddr, edge_addr;
  logic signed [WW-1:0] w_wdata;
  logic [VW-1:0]        s_raddr, s_waddr;
  logic signed [DW:0]   sum;
  logic signed [DW-1:0] cand, s_wdist;

  assign load_ok = (32'(item.from_vertex) < NUM_VERTICES) &&
                   (32'(item.to_vertex) < NUM_VERTICES);
  assign src_ok     = 32'(src) < NUM_VERTICES;
  assign init_reach = src_ok && (k == VW'(src));
  assign edge_addr  = AW'(32'(u) * NUM_VERTICES + 32'(v));

  always_comb begin
    w_we    = cmd.clr_en || (cmd.load_en && load_ok);
    w_waddr = cmd.clr_en ? clr_cnt :
              AW'(32'(item.from_vertex) * NUM_VERTICES + 32'(item.to_vertex));
    w_wdata = cmd.clr_en ? '0 : item.edge_weight;
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rd <= wmem[edge_addr];
  end

  always_comb begin
    sum = {du[DW-1], du} + (DW+1)'(w_rd);
    priority if (sum[DW] != sum[DW-1]) begin
      cand = sum[DW] ? DIST_MIN : DIST_MAX;
    end else begin
      cand = sum[DW-1:0];
    end
    relax = s1_valid && (w_rd != '0) && du_reach && (!reach_rd || (cand < dist_rd));
  end

  always_comb begin
    priority if (cmd.row_rd) begin
      s_raddr = u;
    end else if (cmd.edge_en) begin
      s_raddr = v;
    end else begin
      s_raddr = k;
    end
    s_we    = cmd.init_en || relax;
    s_waddr = cmd.init_en ? k : s1_v;
    s_wdist = cmd.init_en ? '0 : cand;
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      dist_mem[s_waddr]  <= s_wdist;
      reach_mem[s_waddr] <= cmd.init_en ? init_reach : 1'b1;
      pval_mem[s_waddr]  <= !cmd.init_en;
      par_mem[s_waddr]   <= cmd.init_en ? '0 : u;
    end
    dist_rd  <= dist_mem[s_raddr];
    reach_rd <= reach_mem[s_raddr];
    pval_rd  <= pval_mem[s_raddr];
    par_rd   <= par_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    s1_v <= v;
    if (du_load) begin
      du       <= dist_rd;
      du_reach <= reach_rd;
    end else if (relax && (s1_v == u)) begin
      du <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      u            <= '0;
      v            <= '0;
      k            <= '0;
      pass_cnt     <= '0;
      s1_valid     <= 1'b0;
      du_load      <= 1'b0;
      changed_reg  <= 1'b0;
      converged    <= 1'b0;
      src          <= '0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.edge_en;
      du_load  <= cmd.row_rd;
      if (cfg_write) src <= cfg_data;
      if (cmd.clr_en) clr_cnt <= (clr_cnt == LAST_E) ? '0 : clr_cnt + AW'(1);
      if (cmd.init_en || cmd.out_ld) k <= (k == LAST_V) ? '0 : k + VW'(1);
      if (cmd.edge_en) v <= (v == LAST_V) ? '0 : v + VW'(1);
      if (cmd.next_row) u <= (u == LAST_V) ? '0 : u + VW'(1);
      if (cmd.start) begin
        pass_cnt <= '0;
      end else if (cmd.pass_end) begin
        pass_cnt <= pass_cnt + VW'(1);
      end
      if (cmd.start || cmd.pass_end) begin
        changed_reg <= 1'b0;
      end else if (relax) begin
        changed_reg <= 1'b1;
      end
      if (cmd.finish) converged <= !(changed_reg || relax);
      if (cmd.out_ld) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      result.vertex     <= bfsp_pkg::VERTEX_W'(k);
      result.reachable  <= reach_rd;
      result.distance   <= reach_rd ? dist_rd : '0;
      result.has_parent <= pval_rd;
      result.parent     <= pval_rd ? bfsp_pkg::VERTEX_W'(par_rd) : '0;
      result.converged  <= converged;
      result.last       <= (k == LAST_V);
    end
  end

  always_comb begin
    status.clr_last  = clr_cnt == LAST_E;
    status.k_last    = k == LAST_V;
    status.v_last    = v == LAST_V;
    status.u_last    = u == LAST_V;
    status.pass_last = pass_cnt == LAST_V;
    status.changed   = changed_reg || relax;
    status.out_free  = !result_valid || !result_stall;
    status.run_req   = item.cmd == bfsp_pkg::CMD_RUN;
  end

endmodule

// ----- hdl/bellman_ford_shortest_paths_core.sv -----
// Top level of the single-source shortest path core (dense weight matrix).
// Depends on bfsp_pkg, bfsp_ctrl and bfsp_datapath.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------
//   item     | item_valid / item_stall    | bfsp_pkg::item_t
//   result   | result_valid / result_stall| bfsp_pkg::result_t
//   config   | cfg_write                  | cfg_data (source vertex)
//
// After reset a clearing pass empties the weight matrix; items stall. A load
// writes one weight. A run initialises all vertices, then makes relaxation passes (one
// edge per cycle plus a row read and drain per row), at most N passes, then
// registers one result per vertex. The pass count is set by the data, the edge
// rate by the single state memory port. A stalled result holds the output register
// and pauses result production; result_valid does not depend on result_stall.
module bellman_ford_shortest_paths_core #(
  parameter int NUM_VERTICES = bfsp_pkg::DEFAULT_NUM_VERTICES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bfsp_pkg::VERTEX_W-1:0] cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  bfsp_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output bfsp_pkg::result_t             result
);

  bfsp_pkg::ctrl_cmd_t    cmd;
  bfsp_pkg::ctrl_status_t status;

  bfsp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  bfsp_datapath #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item         (item),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- hdl/bfsp_checker.sv -----
// Port-level checks of the shortest path core, bound to its top level.
// Depends on bfsp_pkg and bellman_ford_shortest_paths_core.
module bfsp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input bfsp_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input bfsp_pkg::result_t result
);

  // hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (item.cmd == bfsp_pkg::CMD_RUN) |=> item_stall)
    else $error("item taken right after a run transaction");

  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !item_stall |-> result.last)
    else $error("non-final result pending while accepting items");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.last |=> !result_valid)
    else $error("result follows the final result");

endmodule

bind bellman_ford_shortest_paths_core bfsp_checker u_bfsp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bellman_ford_shortest_paths_core.
// Depends on bfsp_pkg; predicts each run's per-vertex reports from its own weight matrix.
module tb_top;

  localparam int NV = bfsp_pkg::DEFAULT_NUM_VERTICES;
  localparam int HOLD_CYCLES = 3000;
  localparam longint DIST_MAX = 64'sd2147483647;
  localparam longint DIST_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [bfsp_pkg::VERTEX_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  bfsp_pkg::item_t item_bus = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  bfsp_pkg::result_t result_bus;

  bfsp_pkg::item_t pending_cmds[$];
  bfsp_pkg::result_t expected_reports[$];
  logic signed [bfsp_pkg::WEIGHT_W-1:0] edge_weights[NV][NV];
  logic [bfsp_pkg::VERTEX_W-1:0] source_cfg = '0;
  int fail_count = 0;
  bit gaps_on = 1'b1;
  bit hold_phase = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned stall_cycle = 0;

  bellman_ford_shortest_paths_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item_bus),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_bus)
  );

  always #1 clk = ~clk;

  function automatic void predict_shortest_paths();
    int dist_v[NV];
    bit reach[NV];
    bit par_ok[NV];
    logic [bfsp_pkg::VERTEX_W-1:0] par[NV];
    longint sum;
    int cand;
    bit changed;
    bit conv;
    bfsp_pkg::result_t r;
    conv = 1'b0;
    for (int k = 0; k < NV; k++) begin
      dist_v[k] = 0;
      reach[k] = 1'b0;
      par_ok[k] = 1'b0;
      par[k] = '0;
    end
    if (source_cfg < NV) reach[source_cfg] = 1'b1;
    for (int pass = 0; pass < NV && !conv; pass++) begin
      changed = 1'b0;
      for (int u = 0; u < NV; u++) begin
        for (int v = 0; v < NV; v++) begin
          if (edge_weights[u][v] != 0 && reach[u]) begin
            sum = longint'(dist_v[u]) + longint'(edge_weights[u][v]);
            if (sum > DIST_MAX) cand = int'(DIST_MAX);
            else if (sum < DIST_MIN) cand = int'(DIST_MIN);
            else cand = int'(sum);
            if (!reach[v] || cand < dist_v[v]) begin
              dist_v[v] = cand;
              reach[v] = 1'b1;
              par[v] = bfsp_pkg::VERTEX_W'(u);
              par_ok[v] = 1'b1;
              changed = 1'b1;
            end
          end
        end
      end
      if (!changed) conv = 1'b1;
    end
    for (int k = 0; k < NV; k++) begin
      r.vertex = bfsp_pkg::VERTEX_W'(k);
      r.reachable = reach[k];
      r.distance = reach[k] ? dist_v[k] : 0;
      r.has_parent = par_ok[k];
      r.parent = par_ok[k] ? par[k] : '0;
      r.converged = conv;
      r.last = (k == NV - 1);
      expected_reports.push_back(r);
    end
  endfunction

  function automatic string fmt_report(bfsp_pkg::result_t r);
    return $sformatf("v=%0d reach=%0b dist=%0d has_par=%0b par=%0d conv=%0b last=%0b",
                     r.vertex, r.reachable, r.distance, r.has_parent, r.parent,
                     r.converged, r.last);
  endfunction

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!item_valid || !item_stall) begin
      if (gap_left != 0) begin
        item_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        item_bus <= pending_cmds.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          if (!gaps_on) gap_left <= 0;
          else if ($urandom_range(0, 3) == 0) gap_left <= $urandom_range(10, 40);
          else gap_left <= $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: one long hold-off, otherwise a rotating stall pattern
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_phase && !hold_done && result_valid) begin
      result_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      case (stall_cycle[9:8])
        2'd0: result_stall <= 1'b0;
        2'd1: result_stall <= ($urandom_range(0, 3) == 0);
        2'd2: result_stall <= 1'($urandom_range(0, 1));
        default: result_stall <= (stall_cycle % 3 == 0);
      endcase
    end
  end

  // monitor: check vertex reports, then apply the accepted transaction
  always @(posedge clk) begin
    bfsp_pkg::result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (expected_reports.size() == 0) begin
        if (fail_count < 10) $display("unexpected report: %s", fmt_report(result_bus));
        fail_count++;
      end else begin
        exp_r = expected_reports.pop_front();
        if (result_bus.vertex !== exp_r.vertex || result_bus.reachable !== exp_r.reachable ||
            result_bus.distance !== exp_r.distance ||
            result_bus.has_parent !== exp_r.has_parent ||
            result_bus.parent !== exp_r.parent || result_bus.converged !== exp_r.converged ||
            result_bus.last !== exp_r.last) begin
          if (fail_count < 10) begin
            $display("mismatch: expected %s", fmt_report(exp_r));
            $display("          actual   %s", fmt_report(result_bus));
          end
          fail_count++;
        end
      end
    end
    if (!rst && item_valid && !item_stall) begin
      if (item_bus.cmd == bfsp_pkg::CMD_LOAD) begin
        if (item_bus.from_vertex < NV && item_bus.to_vertex < NV)
          edge_weights[item_bus.from_vertex][item_bus.to_vertex] = item_bus.edge_weight;
      end else begin
        predict_shortest_paths();
      end
    end
  end

  task automatic push_load(input int f, input int t,
                           input logic signed [bfsp_pkg::WEIGHT_W-1:0] w);
    bfsp_pkg::item_t it;
    it.cmd = bfsp_pkg::CMD_LOAD;
    it.from_vertex = bfsp_pkg::VERTEX_W'(f);
    it.to_vertex = bfsp_pkg::VERTEX_W'(t);
    it.edge_weight = w;
    pending_cmds.push_back(it);
  endtask

  task automatic push_run();
    bfsp_pkg::item_t it;
    it.cmd = bfsp_pkg::CMD_RUN;
    it.from_vertex = bfsp_pkg::VERTEX_W'($urandom);
    it.to_vertex = bfsp_pkg::VERTEX_W'($urandom);
    it.edge_weight = bfsp_pkg::WEIGHT_W'($urandom);
    pending_cmds.push_back(it);
  endtask

  function automatic logic signed [bfsp_pkg::WEIGHT_W-1:0] pick_weight(input bit mixed);
    int unsigned sel;
    int mag;
    sel = $urandom_range(0, 9);
    mag = $urandom_range(1, 60);
    if (!mixed) return (sel < 3) ? '0 : bfsp_pkg::WEIGHT_W'(mag);
    case (sel)
      0: return '0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3, 4: return bfsp_pkg::WEIGHT_W'($urandom);
      default: return bfsp_pkg::WEIGHT_W'(($urandom_range(0, 9) < 3) ? -mag : mag);
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || item_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_source(input logic [bfsp_pkg::VERTEX_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    source_cfg = v;
  endtask

  task automatic random_phase(input logic [bfsp_pkg::VERTEX_W-1:0] src, input bit mixed,
                              input int n);
    int left;
    int seq;
    wait_idle();
    set_source(src);
    gaps_on = ($urandom_range(0, 3) != 0);
    left = n;
    while (left > 0) begin
      seq = $urandom_range(0, 6);
      for (int i = 0; i < seq && left > 1; i++) begin
        push_load($urandom_range(0, 7), $urandom_range(0, 7), pick_weight(mixed));
        left--;
      end
      push_run();
      left--;
    end
  endtask

  task automatic clear_phase(input logic [bfsp_pkg::VERTEX_W-1:0] src);
    wait_idle();
    set_source(src);
    gaps_on = 1'b0;
    for (int f = 0; f < NV; f++)
      for (int t = 0; t < NV; t++)
        push_load(f, t, '0);
    push_run();
  endtask

  initial begin
    for (int f = 0; f < NV; f++)
      for (int t = 0; t < NV; t++)
        edge_weights[f][t] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_source(0);

    // empty graph, then a negative cycle away from the source
    push_run();
    push_load(0, 1, 16'sh7fff);
    push_load(1, 2, 16'sh8000);
    push_load(2, 3, 5);
    push_load(3, 1, 1);
    push_run();
    // drop the cycle; self-loops on unreachable and reachable vertices
    push_load(3, 1, 0);
    push_load(4, 4, -1);
    push_load(0, 7, -1);
    push_load(7, 7, 1);
    push_run();
    // negative self-loop on the source
    push_load(0, 0, -1);
    push_run();
    push_load(0, 0, 0);
    push_load(7, 0, 16'sh8000);
    push_load(5, 6, 2);
    push_load(6, 5, 3);
    push_run();
    push_load(7, 0, 0);
    push_load(2, 5, 100);
    push_run();
    wait_idle();
    set_source(7);
    push_run();
    push_load(7, 2, 16'sh7fff);
    push_run();

    random_phase(7, 1'b1, 40);
    random_phase(0, 1'b1, 40);
    clear_phase(3);
    random_phase(3, 1'b0, 40);
    random_phase(0, 1'b0, 40);

    // long receiver hold-off while runs keep arriving
    wait_idle();
    set_source(7);
    gaps_on = 1'b0;
    hold_phase = 1'b1;
    push_load(7, 2, 10);
    push_load(2, 4, -3);
    for (int i = 0; i < 6; i++) begin
      push_run();
      push_load($urandom_range(0, 7), $urandom_range(0, 7), pick_weight(1'b0));
    end

    random_phase(5, 1'b1, 40);
    clear_phase(bfsp_pkg::VERTEX_W'($urandom));
    random_phase(bfsp_pkg::VERTEX_W'($urandom), 1'b0, 40);
    random_phase(bfsp_pkg::VERTEX_W'($urandom), 1'b1, 40);

    wait_idle();
    repeat (100) @(posedge clk);
    if (expected_reports.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bfsp_pkg.sv
hdl/bfsp_ctrl.sv
hdl/bfsp_datapath.sv
hdl/bellman_ford_shortest_paths_core.sv
hdl/bfsp_checker.sv
tb/tb_top.sv
